// ===== hw/rtl/rss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the relay safety scheduler
// Holds the defaults for the top-level parameters, the field widths of the
// stream and configuration ports, the register indexes, and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rss_pkg;

    // Defaults for the top-level parameters.
    localparam int RELAY_CHANNELS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF    = 8;
    localparam int TIME_WIDTH_DEF     = 32;

    // Configuration port.
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ON  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP = 1'd1;

    localparam logic [CFG_W-1:0] MAX_ON_RESET  = 32'd10800000;
    localparam logic [CFG_W-1:0] MIN_GAP_RESET = 32'd0;

    // Item fields.
    localparam int RIDX_W  = 2;
    localparam int CMD_W   = RIDX_W + 1;   // {relay_index, turn_on}
    localparam int MASK_W  = 4;
    localparam int COUNT_W = 4;

    localparam int S_TDATA_W   = 8;
    localparam int M_FIELDS_W  = 3 * MASK_W + 2 + COUNT_W;
    localparam int M_TDATA_W   = 24;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input beat taken: tick or enqueue
        logic check;    // apply the on-time watchdog to all relays
        logic drain;    // execute the command at the queue head if allowed
        logic load;     // capture the result into the output register
    } rss_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic queue_empty;
        logic head_blocked;
    } rss_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_ctrl: sequencing controller for the relay safety scheduler
// Takes one beat at a time, steps the datapath through the watchdog check
// and the queue drain, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module rss_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire rss_pkg::rss_stat_t stat,
    output rss_pkg::rss_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       ovalid_reg;
    logic       ovalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        cmd.accept = (state_reg == S_IDLE) && s_tvalid;
        cmd.check  = (state_reg == S_CHECK);
        cmd.drain  = (state_reg == S_DRAIN);
        cmd.load   = (state_reg == S_DONE) && (!ovalid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // One command leaves the queue per cycle until it runs dry
                // or an ON has to wait for the gap.
                if (stat.queue_empty || stat.head_blocked)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("rss_ctrl: input taken while an item is in progress");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_DONE))
        else $error("rss_ctrl: result shown before the item finished");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && !stat.queue_empty && !stat.head_blocked)
        |=> (state_reg == S_DRAIN))
        else $error("rss_ctrl: drain stopped with an executable command");

endmodule

`default_nettype wire

// ===== hw/rtl/rss_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rss_dp: datapath of the relay safety scheduler
// Holds the tick counter, relay states and on stamps, the gap tracker, the
// command queue and the configuration registers, and builds the result beat.
// ----------------------------------------------------------------------------
module rss_dp
#(
    parameter int RELAY_CHANNELS = rss_pkg::RELAY_CHANNELS_DEF,
    parameter int QUEUE_DEPTH    = rss_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH     = rss_pkg::TIME_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rss_pkg::rss_cmd_t               cmd,
    output rss_pkg::rss_stat_t                   stat,
    input  wire logic                            in_op,
    input  wire logic [rss_pkg::RIDX_W-1:0]      in_relay_index,
    input  wire logic                            in_turn_on,
    input  wire logic                            cfg_we,
    input  wire logic [rss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rss_pkg::CFG_W-1:0]       cfg_wdata,
    output logic [rss_pkg::M_TDATA_W-1:0]        out_data
);

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (TIME_WIDTH > rss_pkg::CFG_W) ? TIME_WIDTH : rss_pkg::CFG_W;
    localparam int EXT_W = RELAY_CHANNELS + rss_pkg::MASK_W;
    localparam int PAD_W = rss_pkg::M_TDATA_W - rss_pkg::M_FIELDS_W;

    logic [rss_pkg::CFG_W-1:0]   max_on_reg;
    logic [rss_pkg::CFG_W-1:0]   min_gap_reg;

    logic [TIME_WIDTH-1:0]       tick_reg;
    logic [TIME_WIDTH-1:0]       tick_next;
    logic [TIME_WIDTH-1:0]       last_on_reg;
    logic                        gap_armed_reg;
    logic                        gap_armed_next;

    logic [RELAY_CHANNELS-1:0]   on_reg;
    logic [RELAY_CHANNELS-1:0]   on_next;
    logic [RELAY_CHANNELS-1:0]   expired;
    logic [TIME_WIDTH-1:0]       stamp_reg [RELAY_CHANNELS];

    logic [rss_pkg::CMD_W-1:0]   queue_mem [QUEUE_DEPTH];
    logic [QW-1:0]               head_reg;
    logic [QW-1:0]               head_next;
    logic [FW-1:0]               fill_reg;
    logic [FW-1:0]               fill_next;
    logic [QW:0]                 tail_sum;
    logic [QW-1:0]               tail;

    logic [rss_pkg::MASK_W-1:0]  tmo_reg;
    logic [rss_pkg::MASK_W-1:0]  tmo_next;
    logic                        dropped_reg;
    logic                        dropped_next;
    logic                        waiting_reg;
    logic                        waiting_next;

    logic [rss_pkg::CMD_W-1:0]   head_cmd;
    logic [rss_pkg::RIDX_W-1:0]  head_idx;
    logic                        head_on;
    logic                        head_present;
    logic [TIME_WIDTH-1:0]       since;
    logic                        queue_empty;
    logic                        queue_full;
    logic                        head_blocked;
    logic                        enq;
    logic                        pop;
    logic                        pop_on;

    logic [EXT_W-1:0]            on_ext;
    logic [EXT_W-1:0]            tmo_ext;
    logic [rss_pkg::MASK_W-1:0]  onmask;

    logic [rss_pkg::M_TDATA_W-1:0] out_data_reg;

    // Queue head decode and the gap rule.
    assign head_cmd     = queue_mem[head_reg];
    assign head_on      = head_cmd[0];
    assign head_idx     = head_cmd[rss_pkg::CMD_W-1:1];
    assign head_present = (int'(head_idx) < RELAY_CHANNELS);
    assign since        = tick_reg - last_on_reg;
    assign queue_empty  = (fill_reg == '0);
    assign queue_full   = (fill_reg == FW'(QUEUE_DEPTH));
    assign head_blocked = !queue_empty && head_on && head_present && gap_armed_reg
                          && (CMP_W'(since) < CMP_W'(min_gap_reg));

    assign stat.queue_empty  = queue_empty;
    assign stat.head_blocked = head_blocked;

    assign enq    = cmd.accept && in_op && !queue_full;
    assign pop    = cmd.drain && !queue_empty && !head_blocked;
    assign pop_on = pop && head_present && head_on;

    // Tail slot: head plus fill, folded back once into the queue range.
    assign tail_sum = {1'b0, head_reg} + (QW + 1)'(fill_reg);
    assign tail     = (tail_sum >= (QW + 1)'(QUEUE_DEPTH))
                      ? QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);

    // Watchdog compare, one per relay.
    always_comb
    begin
        for (int i = 0; i < RELAY_CHANNELS; i++)
        begin
            expired[i] = (CMP_W'(tick_reg - stamp_reg[i]) >= CMP_W'(max_on_reg));
        end
    end

    assign tmo_ext = EXT_W'(on_reg & expired);

    always_comb
    begin
        tick_next      = tick_reg;
        on_next        = on_reg;
        gap_armed_next = gap_armed_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        tmo_next       = tmo_reg;
        dropped_next   = dropped_reg;
        waiting_next   = waiting_reg;

        if (cmd.accept)
        begin
            tmo_next     = '0;
            waiting_next = 1'b0;
            dropped_next = in_op && queue_full;
            if (!in_op)
            begin
                tick_next = tick_reg + TIME_WIDTH'(1);
            end
        end

        if (enq)
        begin
            fill_next = fill_reg + FW'(1);
        end

        if (cmd.check)
        begin
            on_next  = on_reg & ~expired;
            tmo_next = tmo_ext[rss_pkg::MASK_W-1:0];
        end

        if (cmd.drain && !queue_empty && head_blocked)
        begin
            waiting_next = 1'b1;
        end

        if (pop)
        begin
            head_next = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
            fill_next = fill_reg - FW'(1);
            if (head_present)
            begin
                for (int i = 0; i < RELAY_CHANNELS; i++)
                begin
                    if (int'(head_idx) == i)
                    begin
                        on_next[i] = head_on;
                    end
                end
            end
            if (pop_on)
            begin
                gap_armed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_on_reg    <= rss_pkg::MAX_ON_RESET;
            min_gap_reg   <= rss_pkg::MIN_GAP_RESET;
            tick_reg      <= '0;
            on_reg        <= '0;
            gap_armed_reg <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            tmo_reg       <= '0;
            dropped_reg   <= 1'b0;
            waiting_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    rss_pkg::REG_MAX_ON:  max_on_reg  <= cfg_wdata;
                    rss_pkg::REG_MIN_GAP: min_gap_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            tick_reg      <= tick_next;
            on_reg        <= on_next;
            gap_armed_reg <= gap_armed_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            tmo_reg       <= tmo_next;
            dropped_reg   <= dropped_next;
            waiting_reg   <= waiting_next;
        end
    end

    // Stamps, last ON time and queue entries are only read once written.
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_mem[tail] <= {in_relay_index, in_turn_on};
        end
        if (pop_on)
        begin
            last_on_reg <= tick_reg;
            for (int i = 0; i < RELAY_CHANNELS; i++)
            begin
                if (int'(head_idx) == i)
                begin
                    stamp_reg[i] <= tick_reg;
                end
            end
        end
    end

    assign on_ext = EXT_W'(on_reg);
    assign onmask = on_ext[rss_pkg::MASK_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {{PAD_W{1'b0}},
                             rss_pkg::COUNT_W'(fill_reg),
                             waiting_reg,
                             dropped_reg,
                             tmo_reg,
                             onmask,
                             ~onmask};
        end
    end

    assign out_data = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("rss_dp: queue fill beyond depth");

    a_waiting_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> !queue_empty)
        else $error("rss_dp: waiting flagged with an empty queue");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !in_op) |=> (tick_reg == $past(tick_reg) + TIME_WIDTH'(1)))
        else $error("rss_dp: tick beat did not advance time");

endmodule

`default_nettype wire

// ===== hw/rtl/relay_safety_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// relay_safety_scheduler: timed, rate-limited driver for a bank of relays
// Takes tick and on/off command beats, queues commands, forces off relays
// that reach their on-time limit, and paces ON commands by a minimum gap.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser op; tdata relay_index, turn_on
//  m_*      out  m_tvalid/m_tready  tdata relay_drive .. queue_count
//  cfg_*    in   cfg_we             cfg_addr register, cfg_wdata value
//
// One beat is in work at a time: after acceptance an item goes through the
// check, drain and done states before the next input slot frees; the drain
// loop executes at most QUEUE_DEPTH queued commands, popping one a cycle. The
// result sits in an output register, so a waiting result only holds the
// block when the next result is ready. Reset is asynchronous and clears time,
// relays, queue pointers and registers; no clearing pass runs.
// ----------------------------------------------------------------------------
module relay_safety_scheduler
#(
    parameter int RELAY_CHANNELS = rss_pkg::RELAY_CHANNELS_DEF,
    parameter int QUEUE_DEPTH    = rss_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH     = rss_pkg::TIME_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] relay_index, [2] turn_on, [7:3] zero
    input  wire logic [rss_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] op
    input  wire logic                            s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] relay_drive, [7:4] relay_on_mask, [11:8] timeout_mask,
    // [12] dropped, [13] waiting, [17:14] queue_count, [23:18] zero
    output logic [rss_pkg::M_TDATA_W-1:0]        m_tdata,

    input  wire logic                            cfg_we,
    input  wire logic [rss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rss_pkg::CFG_W-1:0]       cfg_wdata
);

    rss_pkg::rss_cmd_t  cmd;
    rss_pkg::rss_stat_t stat;

    rss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rss_dp
    #(
        .RELAY_CHANNELS (RELAY_CHANNELS),
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .TIME_WIDTH     (TIME_WIDTH)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_tuser),
        .in_relay_index (s_tdata[rss_pkg::RIDX_W-1:0]),
        .in_turn_on     (s_tdata[rss_pkg::RIDX_W]),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .out_data       (m_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/relay_safety_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_safety_scheduler_checker: scoreboard for the relay safety scheduler
// Watches the input, result and configuration ports. It keeps its own copy
// of the relay bank, clock, command FIFO and registers, predicts the status
// beat for every accepted input beat, and compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module relay_safety_scheduler_checker
    import rss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // [1:0] relay_index, [2] turn_on, [7:3] zero
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // [0] op
    input  wire logic                   s_tuser,

    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // [3:0] relay_drive, [7:4] relay_on_mask, [11:8] timeout_mask,
    // [12] dropped, [13] waiting, [17:14] queue_count, [23:18] zero
    input  wire logic [M_TDATA_W-1:0]   m_tdata,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata,

    output int                          fail_count,
    output int                          pending
);

    // Declared from the top bit down so that it overlays m_tdata[17:0].
    typedef struct packed {
        logic [3:0] queue_count;
        logic       waiting;
        logic       dropped;
        logic [3:0] timeout_mask;
        logic [3:0] on_mask;
        logic [3:0] drive;
    } relay_status_t;

    logic [31:0] max_on;
    logic [31:0] min_gap;
    logic [31:0] tick_now;
    logic [31:0] last_on;
    logic [31:0] on_stamp [4];
    logic [3:0]  relay_on;
    logic        gap_armed;
    logic [2:0]  cmd_fifo [8];    // {relay_index, turn_on}
    logic [2:0]  head;
    logic [3:0]  fill;

    relay_status_t status_q [$];

    function automatic logic head_held();
        logic [2:0] cmd;
        cmd = cmd_fifo[head];
        if (!cmd[0] || !gap_armed)
            return 1'b0;
        return (tick_now - last_on) < min_gap;
    endfunction

    // Advances the bank by one input beat and returns the status it shows.
    function automatic relay_status_t step_bank(input logic is_cmd,
                                                input logic [1:0] ridx,
                                                input logic turn_on);
        relay_status_t res;
        logic [2:0]    slot;
        logic [2:0]    cmd;
        res = '0;
        if (!is_cmd)
            tick_now = tick_now + 32'd1;
        else if (fill == 4'd8)
            res.dropped = 1'b1;
        else
        begin
            slot = head + fill[2:0];
            cmd_fifo[slot] = {ridx, turn_on};
            fill = fill + 4'd1;
        end

        // The watchdog runs before the drain, so a relay switched on by
        // this beat is first checked on the next one.
        for (int i = 0; i < 4; i++)
        begin
            if (relay_on[i] && (tick_now - on_stamp[i]) >= max_on)
            begin
                relay_on[i] = 1'b0;
                on_stamp[i] = '0;
                res.timeout_mask[i] = 1'b1;
            end
        end

        for (int n = 0; n < 8; n++)
        begin
            if (fill == 4'd0)
                break;
            if (head_held())
            begin
                res.waiting = 1'b1;
                break;
            end
            cmd = cmd_fifo[head];
            if (cmd[0])
            begin
                relay_on[cmd[2:1]] = 1'b1;
                on_stamp[cmd[2:1]] = tick_now;
                last_on = tick_now;
                gap_armed = 1'b1;
            end
            else
            begin
                relay_on[cmd[2:1]] = 1'b0;
                on_stamp[cmd[2:1]] = '0;
            end
            head = head + 3'd1;
            fill = fill - 4'd1;
        end

        res.on_mask = relay_on;
        res.drive = ~relay_on;
        res.queue_count = fill;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        relay_status_t want;
        relay_status_t got;
        if (!rst_n)
        begin
            max_on = MAX_ON_RESET;
            min_gap = MIN_GAP_RESET;
            tick_now = '0;
            last_on = '0;
            for (int i = 0; i < 4; i++)
                on_stamp[i] = '0;
            relay_on = '0;
            gap_armed = 1'b0;
            head = '0;
            fill = '0;
            status_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result beat %h with no expected status", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    got = m_tdata[17:0];
                    check_field("relay_drive", want.drive, got.drive);
                    check_field("relay_on_mask", want.on_mask, got.on_mask);
                    check_field("timeout_mask", want.timeout_mask, got.timeout_mask);
                    check_field("dropped", {3'd0, want.dropped}, {3'd0, got.dropped});
                    check_field("waiting", {3'd0, want.waiting}, {3'd0, got.waiting});
                    check_field("queue_count", want.queue_count, got.queue_count);
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MAX_ON:  max_on = cfg_wdata;
                    REG_MIN_GAP: min_gap = cfg_wdata;
                    default:     ;
                endcase
            end

            if (s_tvalid && s_tready)
                status_q.push_back(step_bank(s_tuser, s_tdata[1:0], s_tdata[2]));
        end
        pending = status_q.size();
    end

endmodule

// ===== tb/sv/relay_safety_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_safety_scheduler_test: top of the relay safety scheduler testbench
// Drives ticks and relay commands with random gaps and back-pressure, moves
// the on-time and gap registers through several settings between phases,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module relay_safety_scheduler_test;

    import rss_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_PCT    = 38;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count;
    bit steady;

    relay_safety_scheduler DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    relay_safety_scheduler_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("relay_safety_scheduler_test failed");
        $finish;
    end

    // Offers one beat and returns at the edge that accepts it.
    task automatic send_item(input logic is_cmd, input logic [1:0] ridx,
                             input logic turn_on);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= is_cmd;
        s_tdata <= {5'd0, turn_on, ridx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic apply_cfg(input logic [CFG_W-1:0] max_on,
                             input logic [CFG_W-1:0] min_gap);
        settle();
        cfg_we <= 1'b1;
        cfg_addr <= REG_MAX_ON;
        cfg_wdata <= max_on;
        @(negedge clk);
        cfg_addr <= REG_MIN_GAP;
        cfg_wdata <= min_gap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int tick_pct);
        logic       is_cmd;
        logic [1:0] ridx;
        logic       turn_on;
        is_cmd = $urandom_range(0, 99) >= tick_pct;
        ridx = 2'($urandom_range(0, 3));
        turn_on = $urandom_range(0, 99) < 65;
        send_item(is_cmd, ridx, turn_on);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] max_on,
                             input logic [CFG_W-1:0] min_gap,
                             input int count, input int tick_pct, input bit quiet);
        apply_cfg(max_on, min_gap);
        steady = quiet;
        repeat (count)
            send_random(tick_pct);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_MAX_ON;
        cfg_wdata = '0;
        steady = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: the first ON goes at once, repeated ON and OFFs.
        send_item(1'b0, 2'd3, 1'b1);
        send_item(1'b1, 2'd0, 1'b1);
        send_item(1'b1, 2'd3, 1'b1);
        send_item(1'b1, 2'd3, 1'b1);
        send_item(1'b1, 2'd0, 1'b0);
        send_item(1'b1, 2'd3, 1'b0);
        send_item(1'b0, 2'd0, 1'b0);

        // An endless gap holds the head ON, so the FIFO fills and drops.
        apply_cfg(32'd2, 32'hFFFF_FFFF);
        send_item(1'b1, 2'd1, 1'b1);
        send_item(1'b1, 2'd2, 1'b1);
        send_item(1'b1, 2'd1, 1'b0);
        send_item(1'b1, 2'd0, 1'b1);
        send_item(1'b1, 2'd2, 1'b0);
        send_item(1'b1, 2'd3, 1'b1);
        send_item(1'b1, 2'd0, 1'b0);
        send_item(1'b1, 2'd1, 1'b1);
        send_item(1'b1, 2'd2, 1'b1);
        send_item(1'b0, 2'd2, 1'b1);

        // Opening the gap drains the whole FIFO; short on time trips relays.
        apply_cfg(32'd2, 32'd0);
        send_item(1'b0, 2'd0, 1'b0);
        send_item(1'b0, 2'd1, 1'b0);
        send_item(1'b0, 2'd2, 1'b0);

        // With a zero on time any relay that is on goes off at the next check.
        apply_cfg(32'd0, 32'd0);
        send_item(1'b1, 2'd2, 1'b1);
        send_item(1'b0, 2'd0, 1'b0);

        run_phase(32'd1, 32'd0, 150, 50, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 120, 30, 1'b0);
        run_phase(32'd5, 32'd3, 180, 45, 1'b0);
        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(1, 40), $urandom_range(0, 10), 150, 45, p == 1);
        run_phase(32'd0, 32'd0, 80, 40, 1'b0);
        run_phase(32'd2, 32'd1, 150, 50, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd0, 130, 40, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("relay_safety_scheduler_test passed");
        else
            $display("relay_safety_scheduler_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rss_pkg.sv
hw/rtl/rss_ctrl.sv
hw/rtl/rss_dp.sv
hw/rtl/relay_safety_scheduler.sv
tb/sv/relay_safety_scheduler_checker.sv
tb/sv/relay_safety_scheduler_test.sv
